@@ rtl/core/fc_pkg.sv @@
package fc_pkg;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 11;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int FRAC_W   = 15;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE_TAP = 2'd0,
    FUNC_SAMPLE    = 2'd1,
    FUNC_TAIL      = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_t;

  // controller -> datapath
  typedef struct packed {
    logic tap_wr;
    logic clear;
    logic load;
    logic tail;
    logic issue;
    logic emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
    logic pipe_empty;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/fc_in_if.sv @@
interface fc_in_if import fc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [FUNC_W-1:0]   func;
  logic        [INDEX_W-1:0]  tap_index;
  logic signed [SAMPLE_W-1:0] value;

  modport source (output valid, output func, output tap_index, output value, input ready);
  modport sink   (input valid, input func, input tap_index, input value, output ready);
endinterface

@@ rtl/core/fc_out_if.sv @@
interface fc_out_if import fc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] result;
  logic                       saturated;

  modport source (output valid, output result, output saturated, input ready);
  modport sink   (input valid, input result, input saturated, output ready);
endinterface

@@ rtl/core/fc_ctrl.sv @@
module fc_ctrl import fc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     valid,
  input  func_t    func,
  input  dp_stat_t stat,
  output logic     ready,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ready      = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (valid) begin
          unique case (func)
            FUNC_WRITE_TAP: cmd.tap_wr = 1'b1;
            FUNC_CLEAR:     cmd.clear  = 1'b1;
            FUNC_SAMPLE, FUNC_TAIL: begin
              cmd.load   = 1'b1;
              cmd.tail   = (func == FUNC_TAIL);
              state_next = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the sum to settle and the result register to free up
        if (stat.pipe_empty && stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/fc_datapath.sv @@
module fc_datapath import fc_pkg::*; #(
  parameter int MAX_TAPS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctl_cmd_t                   cmd,
  output dp_stat_t                   stat,
  input  logic                       cfg_we,
  input  logic        [CFG_W-1:0]    cfg_wdata,
  input  logic        [INDEX_W-1:0]  tap_index,
  input  logic signed [SAMPLE_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] result,
  output logic                       saturated
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = PROD_W + AW;
  localparam int Q_W   = ACC_W - FRAC_W;

  logic signed [SAMPLE_W-1:0] tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];

  logic        [CW-1:0]       ntaps;
  logic        [CW-1:0]       fill, fill_next;
  logic        [AW-1:0]       wp, wp_next;
  logic        [AW-1:0]       tap_addr;
  logic        [AW-1:0]       hist_addr;
  logic        [CW-1:0]       left, left_next;
  logic signed [SAMPLE_W-1:0] tap_rd, hist_rd;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       v1, v2;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       tap_ok;
  logic        [CW-1:0]       ntaps_next;
  logic signed [Q_W-1:0]      q;
  logic        [Q_W-FRAC_W-1:0] q_upper;
  logic                       q_sat;

  assign sample  = cmd.tail ? '0 : value;
  assign tap_ok  = 32'(tap_index) < 32'(MAX_TAPS);
  assign wp_next = (32'(wp) == MAX_TAPS - 1) ? '0 : wp + 1'b1;

  // entries older than the samples pushed since the last clear read as zero: skip them
  assign fill_next = (32'(fill) == MAX_TAPS) ? fill : fill + 1'b1;
  assign left_next = (ntaps < fill_next) ? ntaps : fill_next;

  always_comb begin
    if (cfg_wdata == '0) begin
      ntaps_next = CW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_TAPS)) begin
      ntaps_next = CW'(MAX_TAPS);
    end else begin
      ntaps_next = CW'(cfg_wdata);
    end
  end

  assign q       = Q_W'(acc >>> FRAC_W);
  assign q_upper = q[Q_W-1:FRAC_W];
  assign q_sat   = !((&q_upper) || (~|q_upper));

  assign stat.last       = (left == CW'(1));
  assign stat.pipe_empty = !v1 && !v2;
  assign stat.out_free   = !out_valid || out_ready;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.tap_wr && tap_ok) begin
      tap_mem[AW'(tap_index)] <= value;
    end
    if (cmd.issue) begin
      tap_rd <= tap_mem[tap_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hist_mem[wp] <= sample;
    end
    if (cmd.issue) begin
      hist_rd <= hist_mem[hist_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ntaps     <= CW'(1);
      fill      <= '0;
      wp        <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ntaps <= ntaps_next;
      end
      if (cmd.clear) begin
        fill <= '0;
        wp   <= '0;
      end else if (cmd.load) begin
        fill <= fill_next;
        wp   <= wp_next;
      end
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk the taps forward and the history backward
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tap_addr  <= '0;
      hist_addr <= wp;
      left      <= left_next;
    end else if (cmd.issue) begin
      tap_addr  <= tap_addr + 1'b1;
      hist_addr <= (hist_addr == '0) ? AW'(MAX_TAPS - 1) : hist_addr - 1'b1;
      left      <= left - 1'b1;
    end
  end

  // multiply, then accumulate
  always_ff @(posedge clk) begin
    prod <= tap_rd * hist_rd;
    if (cmd.load) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      saturated <= q_sat;
      if (q_sat) begin
        result <= q[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        result <= q[SAMPLE_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/fir_convolver.sv @@
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    func, tap_index, value
// rsp      out  valid/ready    result, saturated
// cfg      in   cfg_we only    cfg_wdata = tap_count
//
// A tap write or a history clear is done while idle. A sample or tail request
// sums N products, N = min(tap_count, samples pushed since the last clear):
// one multiply-accumulate walks the tap and history memories one tap a cycle.
// Reset (rst, synchronous) empties the history through a fill count, so no
// clearing pass is needed; the tap memory stays unknown until written.
// A result waits in the output register under stall while the next request
// is taken; a later sum holds until that register frees up.
module fir_convolver import fc_pkg::*; #(
  parameter int MAX_TAPS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  fc_in_if.sink            req,
  fc_out_if.source         rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // controller: decode each request and sequence the tap walk
  fc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .func  (func_t'(req.func)),
    .stat  (stat),
    .ready (req.ready),
    .cmd   (cmd)
  );

  // datapath: tap and history memories, multiplier, accumulator, result register
  fc_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tap_index (req.tap_index),
    .value     (req.value),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .result    (rsp.result),
    .saturated (rsp.saturated)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// Checks fir_convolver request by request. A short directed table opens the run:
// extreme taps and samples, a tail step, a history clear, and tap counts of zero
// and three. Random phases follow, each with its own tap count and tap set.
// Every accepted request also updates a local convolution predictor. Each sample
// or tail request queues the output it should produce. Each accepted response is
// compared field by field with the oldest queued output.
module tb_top;
  import fc_pkg::*;

  localparam int NUM_TAPS  = 1024;
  localparam int N_PHASES  = 13;
  localparam int N_ROWS    = 22;
  localparam int SETTLE    = 16;    // idle wait after the outputs drain, before a tap_count write
  localparam int TAIL_WAIT = 1100;  // final idle wait; the longest sum walks 1024 taps

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result;
    logic                       saturated;
  } conv_out_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  // One line of the directed table. For a register row, value carries tap_count.
  typedef struct packed {
    row_kind_t                  kind;
    func_t                      func;
    logic [INDEX_W-1:0]         idx;
    logic signed [SAMPLE_W-1:0] value;
    bit                         typed;
    conv_out_t                  want;
  } row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  fc_in_if  req_if ();
  fc_out_if rsp_if ();

  fir_convolver #(.MAX_TAPS(NUM_TAPS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: tap memory, sample history ring, write pointer, tap count.
  logic signed [SAMPLE_W-1:0] tap_model  [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] hist_model [NUM_TAPS];
  logic [INDEX_W-1:0]         hist_wr;
  logic [CFG_W-1:0]           tap_cnt_model;

  conv_out_t conv_outputs [$];  // outputs owed by the block, oldest first
  int        mismatches = 0;
  int        idle_pct   = 20;   // chance of a burst of idle cycles on either side

  // Directed table. Outputs are typed in only where they are plain to see:
  // a single tap on a fresh or cleared history, and the clipping corner.
  row_t plan [0:N_ROWS-1] = '{
    '{ROW_REQ, FUNC_WRITE_TAP, 10'h000, 16'sh8000, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh8000, 1'b1, '{16'sh7fff, 1'b1}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh7fff, 1'b1, '{16'sh8001, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh0001, 1'b1, '{16'shffff, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh0000, 1'b1, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_TAIL,      10'h3ff, 16'sh7fff, 1'b1, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_WRITE_TAP, 10'h000, 16'sh7fff, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh7fff, 1'b1, '{16'sh7ffe, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh8000, 1'b1, '{16'sh8001, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'shffff, 1'b1, '{16'shffff, 1'b0}},
    '{ROW_REQ, FUNC_WRITE_TAP, 10'h001, 16'sh7fff, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_WRITE_TAP, 10'h002, 16'sh8000, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_WRITE_TAP, 10'h3ff, 16'sh5555, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_CFG, FUNC_WRITE_TAP, 10'h000, 16'sh0000, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh7fff, 1'b1, '{16'sh7ffe, 1'b0}},
    '{ROW_CFG, FUNC_WRITE_TAP, 10'h000, 16'sh0003, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh7fff, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh8000, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_CLEAR,     10'h155, 16'shaaaa, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_SAMPLE,    10'h000, 16'sh8000, 1'b1, '{16'sh8001, 1'b0}},
    '{ROW_REQ, FUNC_TAIL,      10'h2aa, 16'sh8000, 1'b0, '{16'sh0000, 1'b0}},
    '{ROW_REQ, FUNC_TAIL,      10'h000, 16'sh1234, 1'b0, '{16'sh0000, 1'b0}}
  };

  // Random phases: tap count and number of requests. Zero and 2047 exercise the
  // clamping of the register; the last phase runs with no idling at all.
  int phase_taps  [N_PHASES] = '{1, 2, 5, 0, 16, 1024, 7, 64, 2047, 33, 3, 128, 4};
  int phase_items [N_PHASES] = '{30, 40, 40, 20, 40, 12, 40, 30, 10, 30, 40, 20, 30};

  // Clamp the register the way the block reads it: zero means one, above max is max.
  function automatic int taps_in_use(input logic [CFG_W-1:0] cnt);
    if (cnt == '0) return 1;
    if (cnt > NUM_TAPS) return NUM_TAPS;
    return int'(cnt);
  endfunction

  // Push one sample into the history ring and form the saturated output.
  function automatic conv_out_t convolve_step(input logic signed [SAMPLE_W-1:0] x);
    conv_out_t          o;
    longint             acc;
    longint             q;
    int                 n;
    logic [INDEX_W-1:0] k;
    hist_model[hist_wr] = x;
    n = taps_in_use(tap_cnt_model);
    acc = 0;
    for (int m = 0; m < n; m++) begin
      // walk back through the ring, wrapping at the memory depth
      k = hist_wr - INDEX_W'(m);
      acc += longint'(tap_model[m]) * longint'(hist_model[k]);
    end
    hist_wr = hist_wr + 1'b1;
    // arithmetic shift rounds toward minus infinity
    q = acc >>> FRAC_W;
    o.saturated = 1'b0;
    if (q > 32767) begin
      q = 32767;
      o.saturated = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      o.saturated = 1'b1;
    end
    o.result = q[SAMPLE_W-1:0];
    return o;
  endfunction

  // Update the predictor for one accepted request and queue its output, if any.
  function automatic void accept_request(input func_t f, input logic [INDEX_W-1:0] idx,
                                         input logic signed [SAMPLE_W-1:0] v,
                                         input bit typed, input conv_out_t fixed);
    conv_out_t o;
    case (f)
      FUNC_WRITE_TAP: begin
        tap_model[idx] = v;
      end
      FUNC_CLEAR: begin
        foreach (hist_model[i]) hist_model[i] = '0;
        hist_wr = '0;
      end
      default: begin
        // a tail step pushes zero whatever value carries
        o = convolve_step((f == FUNC_TAIL) ? 16'sh0000 : v);
        conv_outputs.insert(conv_outputs.size(), typed ? fixed : o);
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Loud taps span the full range and clip often; quiet taps keep the sum in range.
  function automatic logic signed [SAMPLE_W-1:0] tap_value(input bit loud, input int n);
    int lim;
    int t;
    if (loud) return rand_sample();
    lim = 32767 / n;
    t = int'($urandom_range(0, 2 * lim)) - lim;
    return t[SAMPLE_W-1:0];
  endfunction

  // Offer one request, with an optional idle burst first, and hold it until taken.
  task automatic send_req(input func_t f, input logic [INDEX_W-1:0] idx,
                          input logic signed [SAMPLE_W-1:0] v,
                          input bit typed, input conv_out_t fixed);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= f;
    req_if.tap_index <= idx;
    req_if.value     <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    accept_request(f, idx, v, typed, fixed);
  endtask

  // Drop valid, wait for every owed output, then let the block settle.
  task automatic drain_outputs(input int settle);
    req_if.valid <= 1'b0;
    while (conv_outputs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write tap_count only once the block is idle.
  task automatic write_tap_count(input logic [CFG_W-1:0] cnt);
    drain_outputs(SETTLE);
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tap_cnt_model = cnt;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Response side: hold ready low for random bursts, per the phase's idle rate.
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
          stall = $urandom_range(1, 4);
      end
    end
  end

  // Compare each accepted response with the oldest owed output.
  always @(posedge clk) begin : check_rsp
    conv_out_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (conv_outputs.size() == 0) begin
        $error("result: expected none, actual %0d", rsp_if.result);
        mismatches++;
      end else begin
        want = conv_outputs.pop_front();
        if (rsp_if.result !== want.result) begin
          $error("result: expected %0d, actual %0d", want.result, rsp_if.result);
          mismatches++;
        end
        if (rsp_if.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, rsp_if.saturated);
          mismatches++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int  n_eff;
    int  n_load;
    int  sent;
    int  r;
    int  n_tail;
    bit  loud;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_if.valid     <= 1'b0;
    req_if.func      <= FUNC_WRITE_TAP;
    req_if.tap_index <= '0;
    req_if.value     <= '0;
    foreach (tap_model[i]) tap_model[i] = '0;
    foreach (hist_model[i]) hist_model[i] = '0;
    hist_wr = '0;
    tap_cnt_model = 11'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Taps 0..2 are written before any count above one.
    for (int i = 0; i < N_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG)
        write_tap_count(plan[i].value[CFG_W-1:0]);
      else
        send_req(plan[i].func, plan[i].idx, plan[i].value, plan[i].typed, plan[i].want);
    end

    // Random phases. Each opens on an empty history, so a sum reaches back no
    // further than the samples pushed in the phase: load every tap up to that
    // depth first so that no unwritten tap is read.
    for (int p = 0; p < N_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (p == N_PHASES - 1) idle_pct = 0;
      n_eff  = taps_in_use(CFG_W'(phase_taps[p]));
      n_load = (n_eff < phase_items[p] + 8) ? n_eff : phase_items[p] + 8;
      loud   = 1'($urandom_range(0, 1));
      send_req(FUNC_CLEAR, INDEX_W'($urandom), rand_sample(), 1'b0, '0);
      for (int m = 0; m < n_load; m++)
        send_req(FUNC_WRITE_TAP, INDEX_W'(m), tap_value(loud, n_eff), 1'b0, '0);
      write_tap_count(CFG_W'(phase_taps[p]));

      sent = 0;
      while (sent < phase_items[p]) begin
        // halfway through, hold the sender until the block has caught up
        if (sent == phase_items[p] / 2) drain_outputs($urandom_range(1, 8));
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_req(FUNC_SAMPLE, INDEX_W'($urandom), rand_sample(), 1'b0, '0);
          sent++;
        end else if (r < 65) begin
          send_req(FUNC_TAIL, INDEX_W'($urandom), rand_sample(), 1'b0, '0);
          sent++;
        end else if (r < 75) begin
          send_req(FUNC_WRITE_TAP, INDEX_W'($urandom_range(0, NUM_TAPS - 1)),
                   tap_value(loud, n_eff), 1'b0, '0);
          sent++;
        end else if (r < 80) begin
          send_req(FUNC_CLEAR, INDEX_W'($urandom), rand_sample(), 1'b0, '0);
          sent++;
        end else if (r < 88) begin
          // noise: any function, any fields
          send_req(func_t'($urandom_range(0, 3)), INDEX_W'($urandom), rand_sample(),
                   1'b0, '0);
          sent++;
        end else begin
          // end of a stream: drain with tail steps, sometimes followed by a clear
          n_tail = (n_eff > 1) ? ((n_eff - 1 < 6) ? n_eff - 1 : 6) : 1;
          for (int t = 0; t < n_tail; t++) begin
            send_req(FUNC_TAIL, INDEX_W'($urandom), rand_sample(), 1'b0, '0);
            sent++;
          end
          if ($urandom_range(0, 1)) begin
            send_req(FUNC_CLEAR, INDEX_W'($urandom), rand_sample(), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    // Wait out the last outputs, then watch for strays.
    drain_outputs(TAIL_WAIT);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/fc_pkg.sv
rtl/core/fc_in_if.sv
rtl/core/fc_out_if.sv
rtl/core/fc_ctrl.sv
rtl/core/fc_datapath.sv
rtl/core/fir_convolver.sv
tb/sv/tb_top.sv
